// ===== design/i2cms_pkg.sv =====
// Package for the I2C master bit sequencer.
// Holds the command codes, the decoded operation beat and the result record.
// No dependencies.
package i2cms_pkg;

  localparam int BYTE_BITS = 8;
  localparam int CNT_W     = $clog2(BYTE_BITS + 1);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic REQ_COMMAND = 1'b0;

  typedef enum logic [2:0] {
    OP_START,
    OP_STOP,
    OP_WRITE,
    OP_READ,
    OP_TICK
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [BYTE_BITS-1:0] write_data;
    logic                 send_nack;
    logic                 sda_in;
  } op_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 sda_released;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] read_data;
    logic                 ack_missing;
    logic                 rejected;
  } result_t;

endpackage

// ===== design/i2cms_front.sv =====
// Front end: classifies an incoming beat into a decoded operation.
// Depends on i2cms_pkg.
module i2cms_front
  import i2cms_pkg::*;
(
  input  logic                 req_type,
  input  logic [1:0]           command,
  input  logic [BYTE_BITS-1:0] write_data,
  input  logic                 send_nack,
  input  logic                 sda_in,
  output op_t                  op
);

  always_comb begin
    op.write_data = write_data;
    op.send_nack  = send_nack;
    op.sda_in     = sda_in;
    if (req_type != REQ_COMMAND) begin
      op.kind = OP_TICK;
    end else begin
      unique case (command)
        CMD_START: op.kind = OP_START;
        CMD_STOP:  op.kind = OP_STOP;
        CMD_WRITE: op.kind = OP_WRITE;
        CMD_READ:  op.kind = OP_READ;
        default:   op.kind = OP_TICK;
      endcase
    end
  end

endmodule

// ===== design/i2cms_queue.sv =====
// Short queue of decoded operations between front and back.
// Depends on i2cms_pkg.
module i2cms_queue
  import i2cms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output op_t  pop_op,
  output logic not_empty
);

  op_t               entries [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign pop_op    = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/i2cms_back.sv =====
// Back end: line sequencer state machine and result register.
// Depends on i2cms_pkg.
module i2cms_back
  import i2cms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    op_valid,
  input  op_t     op,
  output logic    op_pop,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST1  = 4'd1,
    PH_ST2  = 4'd2,
    PH_ST3  = 4'd3,
    PH_SP1  = 4'd4,
    PH_SP2  = 4'd5,
    PH_WHI  = 4'd6,
    PH_WLO  = 4'd7,
    PH_WAH  = 4'd8,
    PH_WAL  = 4'd9,
    PH_RHI  = 4'd10,
    PH_RLO  = 4'd11,
    PH_RAH  = 4'd12,
    PH_RAL  = 4'd13
  } phase_t;

  phase_t               phase, phase_next;
  logic [CNT_W-1:0]     bit_count, bit_count_next;
  logic [BYTE_BITS-1:0] shift_reg, shift_reg_next;
  logic                 nack_pending, nack_pending_next;
  logic                 scl_reg, scl_reg_next;
  logic                 sda_reg, sda_reg_next;
  logic                 sda_input_mode, sda_input_mode_next;
  result_t              res_next;
  logic [CNT_W-1:0]     bit_inc;

  // Take a new operation whenever the result register is free or draining.
  assign op_pop  = op_valid && (!res_valid || res_ready);
  assign bit_inc = bit_count + 1'b1;

  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    shift_reg_next      = shift_reg;
    nack_pending_next   = nack_pending;
    scl_reg_next        = scl_reg;
    sda_reg_next        = sda_reg;
    sda_input_mode_next = sda_input_mode;
    res_next            = '0;

    if (op.kind == OP_TICK) begin
      unique case (phase)
        PH_IDLE: ;
        PH_ST1: begin
          sda_input_mode_next = 1'b0;
          sda_reg_next        = 1'b1;
          scl_reg_next        = 1'b1;
          phase_next          = PH_ST2;
        end
        PH_ST2: begin
          sda_reg_next = 1'b0;
          phase_next   = PH_ST3;
        end
        PH_ST3: begin
          scl_reg_next      = 1'b0;
          res_next.done_res = 1'b1;
          phase_next        = PH_IDLE;
        end
        PH_SP1: begin
          sda_input_mode_next = 1'b0;
          sda_reg_next        = 1'b0;
          scl_reg_next        = 1'b1;
          phase_next          = PH_SP2;
        end
        PH_SP2: begin
          sda_reg_next      = 1'b1;
          res_next.done_res = 1'b1;
          phase_next        = PH_IDLE;
        end
        PH_WHI: begin
          sda_input_mode_next = 1'b0;
          sda_reg_next        = shift_reg[BYTE_BITS-1];
          scl_reg_next        = 1'b1;
          phase_next          = PH_WLO;
        end
        PH_WLO: begin
          scl_reg_next   = 1'b0;
          shift_reg_next = {shift_reg[BYTE_BITS-2:0], 1'b0};
          bit_count_next = bit_inc;
          phase_next     = (bit_inc >= CNT_W'(BYTE_BITS)) ? PH_WAH : PH_WHI;
        end
        PH_WAH: begin
          sda_input_mode_next = 1'b1;
          scl_reg_next        = 1'b1;
          phase_next          = PH_WAL;
        end
        PH_WAL: begin
          nack_pending_next    = op.sda_in;
          scl_reg_next         = 1'b0;
          sda_input_mode_next  = 1'b0;
          res_next.done_res    = 1'b1;
          res_next.ack_missing = op.sda_in;
          phase_next           = PH_IDLE;
        end
        PH_RHI: begin
          sda_input_mode_next = 1'b1;
          sda_reg_next        = 1'b1;
          scl_reg_next        = 1'b1;
          phase_next          = PH_RLO;
        end
        PH_RLO: begin
          shift_reg_next = {shift_reg[BYTE_BITS-2:0], op.sda_in};
          scl_reg_next   = 1'b0;
          bit_count_next = bit_inc;
          phase_next     = (bit_inc >= CNT_W'(BYTE_BITS)) ? PH_RAH : PH_RHI;
        end
        PH_RAH: begin
          sda_input_mode_next = 1'b0;
          sda_reg_next        = nack_pending;
          scl_reg_next        = 1'b1;
          phase_next          = PH_RAL;
        end
        PH_RAL: begin
          scl_reg_next       = 1'b0;
          res_next.done_res  = 1'b1;
          res_next.read_data = shift_reg;
          phase_next         = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end else if (phase != PH_IDLE) begin
      res_next.rejected = 1'b1;
    end else begin
      bit_count_next = '0;
      unique case (op.kind)
        OP_START: phase_next = PH_ST1;
        OP_STOP:  phase_next = PH_SP1;
        OP_WRITE: begin
          shift_reg_next    = op.write_data;
          nack_pending_next = 1'b0;
          phase_next        = PH_WHI;
        end
        OP_READ: begin
          shift_reg_next    = '0;
          nack_pending_next = op.send_nack;
          phase_next        = PH_RHI;
        end
        default: ;
      endcase
    end

    res_next.scl_level    = scl_reg_next;
    res_next.sda_level    = sda_reg_next;
    res_next.sda_released = sda_input_mode_next;
    res_next.busy_res     = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= '0;
      shift_reg      <= '0;
      nack_pending   <= 1'b0;
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
      sda_input_mode <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (op_pop) begin
        phase          <= phase_next;
        bit_count      <= bit_count_next;
        shift_reg      <= shift_reg_next;
        nack_pending   <= nack_pending_next;
        scl_reg        <= scl_reg_next;
        sda_reg        <= sda_reg_next;
        sda_input_mode <= sda_input_mode_next;
        res_valid      <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      res <= res_next;
    end
  end

endmodule

// ===== design/i2c_master_bit_sequencer.sv =====
// I2C master bit sequencer, top level.
// Depends on i2cms_pkg, i2cms_front, i2cms_queue and i2cms_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item: either a
//   command (req_type 0: start, stop, write byte, read byte) or a half bit
//   period tick (req_type 1) with the sampled SDA level in sda_in.
//   Output channel (out_valid/out_ready) returns exactly one result beat per
//   input beat, in order: the SCL/SDA levels to drive, whether SDA is
//   released, busy, done, the byte read, a missing ACK and a rejected command.
//   A command that arrives while another is still running is dropped and
//   reported with rejected set.
// Path and throughput:
//   A beat passes the front decoder into a two-entry queue, then the back
//   state machine steps one half period and loads the result register,
//   which raises out_valid; one beat per cycle is sustained while out_ready
//   stays high.
// Reset and stalls:
//   rst (synchronous) returns to idle with SCL and SDA high and SDA driven,
//   and empties the queue. When the receiver holds out_ready low, the result
//   register holds, the queue absorbs up to two more beats, then in_ready
//   drops until the output drains.
module i2c_master_bit_sequencer
  import i2cms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  input  logic [1:0]           command,
  input  logic [BYTE_BITS-1:0] write_data,
  input  logic                 send_nack,
  input  logic                 sda_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 scl_level,
  output logic                 sda_level,
  output logic                 sda_released,
  output logic                 busy_res,
  output logic                 done_res,
  output logic [BYTE_BITS-1:0] read_data,
  output logic                 ack_missing,
  output logic                 rejected
);

  op_t     front_op;
  op_t     queue_op;
  logic    queue_full;
  logic    queue_valid;
  logic    queue_pop;
  result_t res;

  // Decode the incoming beat.
  i2cms_front u_front (
    .req_type   (req_type),
    .command    (command),
    .write_data (write_data),
    .send_nack  (send_nack),
    .sda_in     (sda_in),
    .op         (front_op)
  );

  // Accept whenever the queue has room; the back end drains it independently.
  assign in_ready = !queue_full;

  i2cms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_op   (front_op),
    .full      (queue_full),
    .pop       (queue_pop),
    .pop_op    (queue_op),
    .not_empty (queue_valid)
  );

  // Step the line state machine and hold the result for the receiver.
  i2cms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (queue_valid),
    .op        (queue_op),
    .op_pop    (queue_pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign scl_level    = res.scl_level;
  assign sda_level    = res.sda_level;
  assign sda_released = res.sda_released;
  assign busy_res     = res.busy_res;
  assign done_res     = res.done_res;
  assign read_data    = res.read_data;
  assign ack_missing  = res.ack_missing;
  assign rejected     = res.rejected;

  // A finished command leaves the block idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  // A rejected command only happens while a command is running.
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> busy_res && !done_res)
    else $error("rejected reported while idle or done");

  // Status bytes appear only on the finishing beat.
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (ack_missing || read_data != '0) |-> done_res)
    else $error("read data or ack status without done");

  // A beat taken from the queue always lands in the result register.
  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    queue_pop |=> out_valid)
    else $error("popped beat did not produce a result");

endmodule
